// ===== sv/sfb_pkg.sv =====
package sfb_pkg;

  localparam int unsigned NUM_REGS  = 7;
  localparam int unsigned IDX_W     = 3;

  // Register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_FLAG       = 3'd0;
  localparam logic [IDX_W-1:0] REG_ESCAPE     = 3'd1;
  localparam logic [IDX_W-1:0] REG_FLAG_SUB   = 3'd2;
  localparam logic [IDX_W-1:0] REG_ESCAPE_SUB = 3'd3;
  localparam logic [IDX_W-1:0] REG_ADDRESS    = 3'd4;
  localparam logic [IDX_W-1:0] REG_CTRL_EVEN  = 3'd5;
  localparam logic [IDX_W-1:0] REG_CTRL_ODD   = 3'd6;

  // Reset values
  localparam logic [7:0] RST_FLAG       = 8'd126;
  localparam logic [7:0] RST_ESCAPE     = 8'd125;
  localparam logic [7:0] RST_FLAG_SUB   = 8'd94;
  localparam logic [7:0] RST_ESCAPE_SUB = 8'd93;
  localparam logic [7:0] RST_ADDRESS    = 8'd3;
  localparam logic [7:0] RST_CTRL_EVEN  = 8'd0;
  localparam logic [7:0] RST_CTRL_ODD   = 8'd64;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_of_payload;
  } in_word_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_end;
    logic       frame_end;
  } out_word_t;

  typedef struct packed {
    logic [7:0] flag_value;
    logic [7:0] escape_value;
    logic [7:0] flag_substitute;
    logic [7:0] escape_substitute;
    logic [7:0] address_value;
    logic [7:0] control_even;
    logic [7:0] control_odd;
  } cfg_t;

  // Classified word handed from front to back
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last;
    logic       open_frame;
    logic       seq_bit;
    logic [7:0] bcc2;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_FLAG,
    PH_ADDR,
    PH_CTRL,
    PH_BCC1,
    PH_DATA,
    PH_BCC2,
    PH_CLOSE
  } phase_t;

endpackage

// ===== sv/sfb_queue.sv =====
module sfb_queue import sfb_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      head_job,
  output q_status_t status
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  assign head_job     = mem_r[rd_ptr_r];
  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == CW'(DEPTH));

endmodule

// ===== sv/sfb_front.sv =====
module sfb_front import sfb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  input  q_status_t q_status,
  output logic      push,
  output job_t      push_job
);

  logic       inside_r, inside_nxt;
  logic       seq_r, seq_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] xor_sum;

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  // a new frame restarts the check byte
  assign xor_sum = (inside_r ? xor_r : 8'd0) ^ in_word.payload_byte;

  always_comb begin
    push_job.payload_byte = in_word.payload_byte;
    push_job.last         = in_word.last_of_payload;
    push_job.open_frame   = !inside_r;
    push_job.seq_bit      = seq_r;
    push_job.bcc2         = xor_sum;

    inside_nxt = inside_r;
    seq_nxt    = seq_r;
    xor_nxt    = xor_r;
    if (push) begin
      if (in_word.last_of_payload) begin
        inside_nxt = 1'b0;
        seq_nxt    = !seq_r;
        xor_nxt    = 8'd0;
      end else begin
        inside_nxt = 1'b1;
        xor_nxt    = xor_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      seq_r    <= 1'b0;
      xor_r    <= 8'd0;
    end else begin
      inside_r <= inside_nxt;
      seq_r    <= seq_nxt;
      xor_r    <= xor_nxt;
    end
  end

endmodule

// ===== sv/sfb_back.sv =====
module sfb_back import sfb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  job_t      head_job,
  input  q_status_t q_status,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  phase_t     phase_r, phase_nxt;
  phase_t     cur;
  logic       esc_r, esc_nxt;
  logic       out_valid_r;
  out_word_t  out_word_r, word_nxt;
  logic       load, go;
  logic [7:0] ctrl;
  logic [7:0] stuff_val, sub_val;
  logic       is_flag, is_esc;

  assign load = !out_valid_r || !out_stall;
  assign go   = load && !q_status.empty;

  assign cur = (phase_r == PH_START) ? (head_job.open_frame ? PH_FLAG : PH_DATA) : phase_r;

  assign ctrl      = head_job.seq_bit ? cfg.control_odd : cfg.control_even;
  assign stuff_val = (cur == PH_BCC2) ? head_job.bcc2 : head_job.payload_byte;
  // flag rule wins when flag and escape match
  assign is_flag   = (stuff_val == cfg.flag_value);
  assign is_esc    = (stuff_val == cfg.escape_value);
  assign sub_val   = is_flag ? cfg.flag_substitute : cfg.escape_substitute;

  always_comb begin
    phase_nxt          = phase_r;
    esc_nxt            = esc_r;
    pop                = 1'b0;
    word_nxt.line_byte = cfg.flag_value;
    word_nxt.run_end   = 1'b0;
    word_nxt.frame_end = 1'b0;
    unique case (cur)
      PH_START, PH_FLAG: begin
        word_nxt.line_byte = cfg.flag_value;
        phase_nxt          = PH_ADDR;
      end
      PH_ADDR: begin
        word_nxt.line_byte = cfg.address_value;
        phase_nxt          = PH_CTRL;
      end
      PH_CTRL: begin
        word_nxt.line_byte = ctrl;
        phase_nxt          = PH_BCC1;
      end
      PH_BCC1: begin
        word_nxt.line_byte = cfg.address_value ^ ctrl;
        phase_nxt          = PH_DATA;
      end
      PH_DATA, PH_BCC2: begin
        if (esc_r) begin
          word_nxt.line_byte = sub_val;
          esc_nxt            = 1'b0;
        end else if (is_flag || is_esc) begin
          word_nxt.line_byte = cfg.escape_value;
          esc_nxt            = 1'b1;
        end else begin
          word_nxt.line_byte = stuff_val;
        end
        phase_nxt = cur;
        // byte finished once no escape half is left
        if (esc_r || !(is_flag || is_esc)) begin
          if (cur == PH_BCC2) begin
            phase_nxt = PH_CLOSE;
          end else if (head_job.last) begin
            phase_nxt = PH_BCC2;
          end else begin
            word_nxt.run_end = 1'b1;
            phase_nxt        = PH_START;
            pop              = go;
          end
        end
      end
      PH_CLOSE: begin
        word_nxt.line_byte = cfg.flag_value;
        word_nxt.run_end   = 1'b1;
        word_nxt.frame_end = 1'b1;
        phase_nxt          = PH_START;
        pop                = go;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      esc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (go) begin
        phase_r <= phase_nxt;
        esc_r   <= esc_nxt;
      end
      if (load) begin
        out_valid_r <= go;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_word_r <= word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== sv/stuffed_frame_builder.sv =====
// Stuffed frame builder: payload words in, HDLC-style framed line words out.
// Input channel (in_valid / in_stall / in_word): one payload byte per word,
//   with last_of_payload closing the frame. A word is taken when in_valid is
//   high and in_stall low; in_stall rises only when the job queue is full.
// Output channel (out_valid / out_stall / out_word): one line byte per word.
//   run_end marks the last byte caused by an input word, frame_end the
//   closing flag. The output register holds its word while out_stall is high.
// Config port (cfg_wr_en / cfg_index / cfg_data): write registers 0..6
//   (flag, escape, two substitutes, address, even and odd control); other
//   indexes are dropped. Write only while the block is idle.
// Flow: the front takes one word per cycle into a QUEUE_DEPTH-entry queue
//   unless in_stall is high. The back sequencer emits one line byte per
//   cycle while the queue holds a word and out_stall allows it; a word gives
//   one line byte, plus one if stuffed, plus 4 for a header, plus 2..3 for
//   BCC2 and the closing flag on a last word. The first line byte passes
//   through the queue and then the output register before it is presented.
//   The back sequencer's byte rate sets the sustained word rate.
// Reset (rst_n low, synchronous): no frame open, sequence bit 0, queue and
//   output register empty, config back to defaults.
module stuffed_frame_builder import sfb_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_word,
  input  logic             cfg_wr_en,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [7:0]       cfg_data
);

  cfg_t      cfg_r, cfg_nxt;
  q_status_t q_status;
  logic      push, pop;
  job_t      push_job, head_job;

  // Config registers, held here and shared by the back end
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FLAG:       cfg_nxt.flag_value        = cfg_data;
        REG_ESCAPE:     cfg_nxt.escape_value      = cfg_data;
        REG_FLAG_SUB:   cfg_nxt.flag_substitute   = cfg_data;
        REG_ESCAPE_SUB: cfg_nxt.escape_substitute = cfg_data;
        REG_ADDRESS:    cfg_nxt.address_value     = cfg_data;
        REG_CTRL_EVEN:  cfg_nxt.control_even      = cfg_data;
        REG_CTRL_ODD:   cfg_nxt.control_odd       = cfg_data;
        default:        cfg_nxt = cfg_r; // index out of range: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag_value        <= RST_FLAG;
      cfg_r.escape_value      <= RST_ESCAPE;
      cfg_r.flag_substitute   <= RST_FLAG_SUB;
      cfg_r.escape_substitute <= RST_ESCAPE_SUB;
      cfg_r.address_value     <= RST_ADDRESS;
      cfg_r.control_even      <= RST_CTRL_EVEN;
      cfg_r.control_odd       <= RST_CTRL_ODD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: frame tracking, sequence bit, running BCC2
  sfb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  // Queue decouples acceptance from emission
  sfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  // Back: header, stuffing, BCC2 and closing flag, one byte a cycle unless stalled or the queue is empty
  sfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head_job  (head_job),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

`ifndef ASSERT_OFF
  // closing flag always ends its input word's run
  a_fend_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.frame_end |-> out_word.run_end)
    else $error("frame_end without run_end");

  // closing flag carries the flag register
  a_fend_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.frame_end |-> out_word.line_byte == cfg_r.flag_value)
    else $error("closing byte is not the flag");

  // queue status is consistent
  a_q_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.empty && q_status.full))
    else $error("queue both empty and full");

  // no pop from an empty queue
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("pop while queue empty");
`endif

endmodule
